FILE: src/pba_pkg.sv
// Shared types and constants for the paged bump allocator.
// Used by the controller, datapath and top level; no dependencies.
package pba_pkg;

  localparam int          MAX_PAGES_DEF = 8;
  localparam logic [31:0] DEF_PAGE_SIZE = 32'h0001_0000;
  localparam int          PIDX_W        = 3;

  localparam logic CMD_ALLOC   = 1'b0;
  localparam logic CMD_DISCARD = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_SCAN = 4'b0010,
    ST_GROW = 4'b0100,
    ST_DONE = 4'b1000
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic take;
    logic scan_next;
    logic grow_step;
    logic commit_hit;
    logic commit_new;
    logic commit_fail;
    logic commit_discard;
    logic out_valid;
  } ctrl_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic in_valid;
    logic in_discard;
    logic piu_zero;
    logic fit;
    logic last;
    logic full;
    logic grow_done;
    logic out_ready;
  } dp_stat_t;

  // Alignment rounded down to its highest set bit, minus one; zero gives zero.
  function automatic logic [15:0] align_mask(logic [16:0] a);
    logic [15:0] m;
    m = '0;
    for (int i = 1; i < 17; i++) begin
      if (a[i]) m = 16'((17'd1 << i) - 17'd1);
    end
    return m;
  endfunction

endpackage

FILE: src/pba_ifs.sv
// Channel interfaces for the paged bump allocator: request, result, config.
// Depends on nothing.
interface pba_in_if;
  logic        valid;
  logic        ready;
  logic        command;
  logic [31:0] size;
  logic [16:0] alignment;
  modport source (output valid, command, size, alignment, input ready);
  modport sink   (input valid, command, size, alignment, output ready);
endinterface

interface pba_out_if;
  logic        valid;
  logic        ready;
  logic        ok;
  logic [2:0]  page_index;
  logic [31:0] offset;
  logic        new_page;
  modport source (output valid, ok, page_index, offset, new_page, input ready);
  modport sink   (input valid, ok, page_index, offset, new_page, output ready);
endinterface

interface pba_cfg_if;
  logic        valid;
  logic        ready;
  logic [31:0] default_page_size;
  modport source (output valid, default_page_size, input ready);
  modport sink   (input valid, default_page_size, output ready);
endinterface

FILE: src/pba_ctrl.sv
// Sequencing state machine for the paged bump allocator.
// Depends on pba_pkg; talks to pba_dp only through command/status structs.
module pba_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  pba_pkg::dp_stat_t stat,
  output pba_pkg::ctrl_cmd_t cmd
);

  pba_pkg::state_t state_r, state_nxt;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    case (state_r)
      pba_pkg::ST_IDLE: begin
        cmd.take = 1'b1;
        if (stat.in_valid) begin
          if (stat.in_discard) begin
            cmd.commit_discard = 1'b1;
            state_nxt          = pba_pkg::ST_DONE;
          end else if (stat.piu_zero) begin
            state_nxt = pba_pkg::ST_GROW;
          end else begin
            state_nxt = pba_pkg::ST_SCAN;
          end
        end
      end
      pba_pkg::ST_SCAN: begin
        if (stat.fit) begin
          cmd.commit_hit = 1'b1;
          state_nxt      = pba_pkg::ST_DONE;
        end else if (stat.last) begin
          if (stat.full) begin
            cmd.commit_fail = 1'b1;
            state_nxt       = pba_pkg::ST_DONE;
          end else begin
            state_nxt = pba_pkg::ST_GROW;
          end
        end else begin
          cmd.scan_next = 1'b1;
        end
      end
      pba_pkg::ST_GROW: begin
        if (stat.grow_done) begin
          cmd.commit_new = 1'b1;
          state_nxt      = pba_pkg::ST_DONE;
        end else begin
          cmd.grow_step = 1'b1;
        end
      end
      pba_pkg::ST_DONE: begin
        cmd.out_valid = 1'b1;
        if (stat.out_ready) state_nxt = pba_pkg::ST_IDLE;
      end
      default: state_nxt = pba_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= pba_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

FILE: src/pba_dp.sv
// Datapath: page table memories, scan index, page-size doubler, result regs.
// Depends on pba_pkg and the channel interfaces in pba_ifs.
module pba_dp #(
  parameter int MAX_PAGES = pba_pkg::MAX_PAGES_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  pba_in_if.sink             in_ch,
  pba_out_if.source          out_ch,
  pba_cfg_if.sink            cfg_ch,
  input  pba_pkg::ctrl_cmd_t cmd,
  output pba_pkg::dp_stat_t  stat
);

  localparam int IDXW = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;
  localparam int PIUW = $clog2(MAX_PAGES + 1);
  localparam int OW   = pba_pkg::PIDX_W;

  logic [32:0] bytes_mem [MAX_PAGES];
  logic [32:0] fill_mem  [MAX_PAGES];

  logic [31:0]     dps_r;
  logic [PIUW-1:0] piu_r;
  logic [IDXW-1:0] idx_r;
  logic [31:0]     size_r;
  logic [15:0]     mask_r;
  logic [32:0]     psize_r;
  logic [32:0]     rd_bytes_r, rd_fill_r;

  logic          ok_r, np_r;
  logic [OW-1:0] pidx_r;
  logic [31:0]   off_r;

  logic            accept;
  logic [IDXW-1:0] rd_addr;
  logic [IDXW-1:0] new_addr;
  logic [33:0]     aligned;
  logic [32:0]     end_off;
  logic [32:0]     dps_eff;

  assign accept   = cmd.take & in_ch.valid;
  assign new_addr = piu_r[IDXW-1:0];
  assign dps_eff  = (dps_r == 32'd0) ? 33'd1 : {1'b0, dps_r};

  // round the fill up to the alignment, then check the region end
  assign aligned = ({1'b0, rd_fill_r} + {18'd0, mask_r}) & ~{18'd0, mask_r};
  assign end_off = {1'b0, aligned[31:0]} + {1'b0, size_r};

  assign in_ch.ready  = cmd.take;
  assign cfg_ch.ready = 1'b1;

  assign stat.in_valid   = in_ch.valid;
  assign stat.in_discard = (in_ch.command == pba_pkg::CMD_DISCARD);
  assign stat.piu_zero   = (piu_r == '0);
  assign stat.fit        = (aligned[33:32] == 2'b00) && (end_off <= rd_bytes_r);
  assign stat.last       = ((PIUW'(idx_r) + PIUW'(1)) == piu_r);
  assign stat.full       = (piu_r == PIUW'(MAX_PAGES));
  assign stat.grow_done  = (psize_r >= {1'b0, size_r});
  assign stat.out_ready  = out_ch.ready;

  assign out_ch.valid      = cmd.out_valid;
  assign out_ch.ok         = ok_r;
  assign out_ch.page_index = pidx_r;
  assign out_ch.offset     = off_r;
  assign out_ch.new_page   = np_r;

  always_comb begin
    if (cmd.scan_next)  rd_addr = IDXW'(idx_r + IDXW'(1));
    else if (cmd.take)  rd_addr = '0;
    else                rd_addr = idx_r;
  end

  // page table: one write and one registered read per cycle
  always_ff @(posedge clk) begin
    rd_bytes_r <= bytes_mem[rd_addr];
    rd_fill_r  <= fill_mem[rd_addr];
    if (cmd.commit_new) begin
      bytes_mem[new_addr] <= psize_r;
    end
    if (cmd.commit_hit) begin
      fill_mem[idx_r] <= {1'b0, end_off[31:0]} | {end_off[32], 32'd0};
    end else if (cmd.commit_new) begin
      fill_mem[new_addr] <= {1'b0, size_r};
    end else if (cmd.commit_discard && (piu_r != '0)) begin
      fill_mem[0] <= '0;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      piu_r <= '0;
      dps_r <= pba_pkg::DEF_PAGE_SIZE;
    end else begin
      if (cfg_ch.valid) dps_r <= cfg_ch.default_page_size;
      if (cmd.commit_new) begin
        piu_r <= PIUW'(piu_r + PIUW'(1));
      end else if (cmd.commit_discard && (piu_r != '0)) begin
        piu_r <= PIUW'(1);
      end
    end
  end

  // request and result registers
  always_ff @(posedge clk) begin
    if (accept) begin
      size_r  <= in_ch.size;
      mask_r  <= pba_pkg::align_mask(in_ch.alignment);
      idx_r   <= '0;
      psize_r <= dps_eff;
    end else begin
      if (cmd.scan_next) idx_r <= IDXW'(idx_r + IDXW'(1));
      if (cmd.grow_step) psize_r <= {psize_r[31:0], 1'b0};
    end

    if (cmd.commit_hit) begin
      ok_r   <= 1'b1;
      pidx_r <= OW'(idx_r);
      off_r  <= aligned[31:0];
      np_r   <= 1'b0;
    end else if (cmd.commit_new) begin
      ok_r   <= 1'b1;
      pidx_r <= OW'(piu_r);
      off_r  <= '0;
      np_r   <= 1'b1;
    end else if (cmd.commit_fail || cmd.commit_discard) begin
      ok_r   <= cmd.commit_discard;
      pidx_r <= '0;
      off_r  <= '0;
      np_r   <= 1'b0;
    end
  end

endmodule

FILE: src/paged_bump_allocator.sv
// Top level of the paged bump allocator: controller plus datapath.
// Depends on pba_pkg, pba_ifs, pba_ctrl and pba_dp.
//
// Usage:
//   in_ch  - request items: command (allocate or discard), size, alignment.
//   out_ch - one result item per request: ok, page_index, offset, new_page.
//   cfg_ch - writes default_page_size; always ready, write only while idle.
// One request is in flight at a time. Sequence per item, from accept:
//   discard                : result valid in the cycle after accept.
//   allocate, page hit     : scan of k pages, k = pages visited (1..MAX_PAGES);
//                            the first-fit scan reads one page table entry
//                            per cycle.
//   allocate, new page     : scan of all pages in use, then d = number of
//                            doublings of the default page size (0..32), one
//                            per cycle in the size doubler, then the result.
//   allocate, table full   : scan of all MAX_PAGES pages, result has ok = 0.
// The result then waits in its register until out_ch.ready; in_ch.ready is
// low from accept until the result is taken and high again on the next cycle.
// Reset (rst_n low, synchronous) empties the page table (no pages in use)
// and loads the default page size with 64 KiB; no clearing pass is needed.
module paged_bump_allocator #(
  parameter int MAX_PAGES = pba_pkg::MAX_PAGES_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  pba_in_if.sink    in_ch,
  pba_out_if.source out_ch,
  pba_cfg_if.sink   cfg_ch
);

  pba_pkg::ctrl_cmd_t cmd;
  pba_pkg::dp_stat_t  stat;

  pba_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .stat  (stat),
    .cmd   (cmd)
  );

  pba_dp #(
    .MAX_PAGES (MAX_PAGES)
  ) u_dp (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch),
    .cmd    (cmd),
    .stat   (stat)
  );

endmodule
